// ===== rtl/core/box_subtract_split_3d_defines.svh =====
// ---------------------------------------------------------------------------
// Box subtract split 3D: assertion macros
// Shared property wrappers for the checks in the block's top level.
// ---------------------------------------------------------------------------
`ifndef BOX_SUBTRACT_SPLIT_3D_DEFINES_SVH
`define BOX_SUBTRACT_SPLIT_3D_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BSS3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define BSS3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bss3_pkg.sv =====
// ---------------------------------------------------------------------------
// Box subtract split 3D: package
// Coordinate, box, side and status types shared by the split datapath.
// ---------------------------------------------------------------------------
package bss3_pkg;

    localparam int COORD_BITS  = 16;
    localparam int NUM_SIDES   = 6;
    localparam int IN_DATA_W   = 12 * COORD_BITS;
    localparam int OUT_DATA_W  = 6 * COORD_BITS;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [2:0]            t_side;
    typedef logic [1:0]            t_status;
    typedef logic [NUM_SIDES-1:0]  t_mask;

    // Side codes, also the slot index of each piece
    localparam t_side SIDE_ABOVE  = 3'd0;
    localparam t_side SIDE_BELOW  = 3'd1;
    localparam t_side SIDE_HIGH_Y = 3'd2;
    localparam t_side SIDE_LOW_Y  = 3'd3;
    localparam t_side SIDE_HIGH_X = 3'd4;
    localparam t_side SIDE_LOW_X  = 3'd5;

    localparam t_status STAT_OK      = 2'd0;
    localparam t_status STAT_COVERED = 2'd1;
    localparam t_status STAT_NO_OVL  = 2'd2;

    // First member is most significant: high x ends up in the lowest bits
    typedef struct packed {
        t_coord lz;
        t_coord ly;
        t_coord lx;
        t_coord hz;
        t_coord hy;
        t_coord hx;
    } t_box;

    // Input item: box in the low half, cutter in the high half
    typedef struct packed {
        t_box cut;
        t_box box;
    } t_pair;

    // Result user field: side lowest, status above it
    typedef struct packed {
        t_status status;
        t_side   side;
    } t_user;

    // Split result handed from the datapath to the emitter
    typedef struct packed {
        t_mask                 mask;
        t_status               status;
        t_box [NUM_SIDES-1:0]  piece;
    } t_split;

    function automatic t_box mk_box(t_coord hx, t_coord hy, t_coord hz,
                                    t_coord lx, t_coord ly, t_coord lz);
        t_box b;
        b.hx = hx;
        b.hy = hy;
        b.hz = hz;
        b.lx = lx;
        b.ly = ly;
        b.lz = lz;
        return b;
    endfunction

endpackage

// ===== rtl/core/bss3_calc.sv =====
// ---------------------------------------------------------------------------
// Box subtract split 3D: split datapath
// Orders both boxes, tests overlap, clamps the cutter and forms all six
// candidate pieces with a mask of the ones that are non-empty.
// ---------------------------------------------------------------------------
module bss3_calc (
    input  bss3_pkg::t_pair  i_pair,
    output bss3_pkg::t_split o_split
);
    import bss3_pkg::*;

    always_comb begin
        t_coord bh [3];
        t_coord bl [3];
        t_coord ch [3];
        t_coord cl [3];
        t_coord sh [3];
        t_coord sl [3];
        t_coord raw_bh [3];
        t_coord raw_bl [3];
        t_coord raw_ch [3];
        t_coord raw_cl [3];
        logic   overlap;
        t_mask  cond;

        raw_bh[0] = i_pair.box.hx; raw_bh[1] = i_pair.box.hy; raw_bh[2] = i_pair.box.hz;
        raw_bl[0] = i_pair.box.lx; raw_bl[1] = i_pair.box.ly; raw_bl[2] = i_pair.box.lz;
        raw_ch[0] = i_pair.cut.hx; raw_ch[1] = i_pair.cut.hy; raw_ch[2] = i_pair.cut.hz;
        raw_cl[0] = i_pair.cut.lx; raw_cl[1] = i_pair.cut.ly; raw_cl[2] = i_pair.cut.lz;

        // Swap corners given the wrong way round, then clamp cutter to box
        overlap = 1'b1;
        for (int a = 0; a < 3; a++) begin
            bh[a] = (raw_bh[a] < raw_bl[a]) ? raw_bl[a] : raw_bh[a];
            bl[a] = (raw_bh[a] < raw_bl[a]) ? raw_bh[a] : raw_bl[a];
            ch[a] = (raw_ch[a] < raw_cl[a]) ? raw_cl[a] : raw_ch[a];
            cl[a] = (raw_ch[a] < raw_cl[a]) ? raw_ch[a] : raw_cl[a];
            if (bh[a] < cl[a] || bl[a] > ch[a]) begin
                overlap = 1'b0;
            end
            sh[a] = (ch[a] < bh[a]) ? ch[a] : bh[a];
            sl[a] = (cl[a] > bl[a]) ? cl[a] : bl[a];
        end

        // Non-empty pieces, one bit per side code
        cond[SIDE_ABOVE]  = bh[2] > sh[2];
        cond[SIDE_BELOW]  = bl[2] < sl[2];
        cond[SIDE_HIGH_Y] = bh[1] > sh[1];
        cond[SIDE_LOW_Y]  = bl[1] < sl[1];
        cond[SIDE_HIGH_X] = bh[0] > sh[0];
        cond[SIDE_LOW_X]  = bl[0] < sl[0];

        // Candidate pieces; the +1 and -1 cannot wrap where the bit is set
        o_split.piece[SIDE_ABOVE]  = mk_box(bh[0], bh[1], bh[2],
                                            bl[0], bl[1], sh[2] + t_coord'(1));
        o_split.piece[SIDE_BELOW]  = mk_box(bh[0], bh[1], sl[2] - t_coord'(1),
                                            bl[0], bl[1], bl[2]);
        o_split.piece[SIDE_HIGH_Y] = mk_box(bh[0], bh[1], sh[2],
                                            bl[0], sh[1] + t_coord'(1), sl[2]);
        o_split.piece[SIDE_LOW_Y]  = mk_box(bh[0], sl[1] - t_coord'(1), sh[2],
                                            bl[0], bl[1], sl[2]);
        o_split.piece[SIDE_HIGH_X] = mk_box(bh[0], sh[1], sh[2],
                                            sh[0] + t_coord'(1), sl[1], sl[2]);
        o_split.piece[SIDE_LOW_X]  = mk_box(sl[0] - t_coord'(1), sh[1], sh[2],
                                            bl[0], sl[1], sl[2]);
        o_split.mask   = cond;
        o_split.status = STAT_OK;

        // Disjoint boxes: emit the ordered box alone in the first slot
        if (!overlap) begin
            o_split.mask   = t_mask'(1);
            o_split.status = STAT_NO_OVL;
            o_split.piece[SIDE_ABOVE] = mk_box(bh[0], bh[1], bh[2], bl[0], bl[1], bl[2]);
        end else if (cond == '0) begin
            // Cutter swallows the whole box: one empty result
            o_split.mask   = t_mask'(1);
            o_split.status = STAT_COVERED;
            o_split.piece[SIDE_ABOVE] = '0;
        end
    end

endmodule

// ===== rtl/core/bss3_emit.sv =====
// ---------------------------------------------------------------------------
// Box subtract split 3D: piece emitter
// Holds one item's pieces in a bank and sends the pending ones, lowest
// side code first, through an output register, one per cycle unless stalled.
// ---------------------------------------------------------------------------
module bss3_emit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_load_valid,
    input  bss3_pkg::t_split                      i_split,
    output logic                                  o_bank_free,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // piece_high_x, piece_high_y, piece_high_z, piece_low_x, piece_low_y,
    // piece_low_z (lowest bits first)
    output logic [bss3_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // side, status (lowest bits first)
    output bss3_pkg::t_user                       m_axis_tuser,
    output logic                                  m_axis_tlast
);
    import bss3_pkg::*;

    t_mask                 r_mask;
    t_mask                 n_mask;
    t_status               r_status;
    t_box [NUM_SIDES-1:0]  r_piece;
    logic                  r_out_valid;
    t_box                  r_out_box;
    t_user                 r_out_user;
    logic                  r_out_last;

    logic  out_adv;
    logic  pick_valid;
    t_side pick_idx;
    t_mask rest;
    logic  bank_load;

    // Pick the lowest pending slot
    always_comb begin
        pick_idx = SIDE_ABOVE;
        for (int i = NUM_SIDES - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                pick_idx = t_side'(i);
            end
        end
    end

    assign pick_valid  = r_mask != '0;
    assign out_adv     = !r_out_valid || m_axis_tready;
    assign rest        = r_mask & ~(t_mask'(1) << pick_idx);
    assign o_bank_free = !pick_valid || (out_adv && rest == '0);
    assign bank_load   = i_load_valid && o_bank_free;

    // Clear the slot being sent, or refill with the next item
    always_comb begin
        n_mask = r_mask;
        if (out_adv && pick_valid) begin
            n_mask = rest;
        end
        if (bank_load) begin
            n_mask = i_split.mask;
        end
    end

    // Hold bank control and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (out_adv) begin
                r_out_valid <= pick_valid;
            end
        end
    end

    // Bank and output payload
    always_ff @(posedge i_clk) begin
        if (bank_load) begin
            r_piece  <= i_split.piece;
            r_status <= i_split.status;
        end
        if (out_adv && pick_valid) begin
            r_out_box         <= r_piece[pick_idx];
            r_out_user.side   <= pick_idx;
            r_out_user.status <= r_status;
            r_out_last        <= rest == '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_box;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== rtl/core/box_subtract_split_3d.sv =====
// ---------------------------------------------------------------------------
// Box subtract split 3D
// Splits a box by a cutting box into the disjoint pieces of box minus cutter.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one box pair per item: the box corners in tdata bits
//   [95:0] and the cutter corners in [191:96]. m_axis returns one result per
//   item: piece corners in tdata, side and status in tuser, and tlast on the
//   final result of each input item.
//   Pieces come out above, below, higher y, lower y, higher x, lower x,
//   skipping empty ones. Disjoint boxes give one result holding the ordered
//   box with no-overlap status; a fully covered box gives one zeroed result
//   with covered status.
//   The first result of an item passes through the input register, the
//   piece bank and the output register before it is valid.
//   Throughput: one result per cycle while m_axis_tready is high, so an
//   item holds the piece bank until its 1 to 6 results have all left it;
//   the emitter's single output port sets that rate. The next item is
//   taken while the last result of the previous one is being sent.
//   Reset empties all three stages. A stalled receiver holds the output
//   register; the bank and input register fill and s_axis_tready drops.
// ---------------------------------------------------------------------------
`include "box_subtract_split_3d_defines.svh"

module box_subtract_split_3d (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // box_high_x, box_high_y, box_high_z, box_low_x, box_low_y, box_low_z,
    // cut_high_x, cut_high_y, cut_high_z, cut_low_x, cut_low_y, cut_low_z
    // (lowest bits first)
    input  logic [bss3_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // piece_high_x, piece_high_y, piece_high_z, piece_low_x, piece_low_y,
    // piece_low_z (lowest bits first)
    output logic [bss3_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // side (3 bits), status (2 bits) (lowest bits first)
    output logic [4:0]                            m_axis_tuser,
    output logic                                  m_axis_tlast
);
    import bss3_pkg::*;

    logic   r_in_valid;
    t_pair  r_in_pair;
    t_split split;
    logic   bank_free;
    t_user  out_user;

    assign s_axis_tready = !r_in_valid || bank_free;

    // Input register: advance when empty or when the bank takes the held item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_pair <= t_pair'(s_axis_tdata);
        end
    end

    bss3_calc u_calc (
        .i_pair  (r_in_pair),
        .o_split (split)
    );

    bss3_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load_valid  (r_in_valid),
        .i_split       (split),
        .o_bank_free   (bank_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (out_user),
        .m_axis_tlast  (m_axis_tlast)
    );

    assign m_axis_tuser = out_user;

    // Special results stand alone
    `BSS3_ASSERT_NOW(a_special_is_last, i_clk, i_rst_n,
        m_axis_tvalid && out_user.status != STAT_OK, m_axis_tlast,
        "no-overlap or covered result not marked last")
    // Pieces still pending in the bank follow without a gap
    `BSS3_ASSERT_NEXT(a_pieces_continue, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid,
        "gap inside one item's pieces")
    // Back-pressure only when an item is held
    `BSS3_ASSERT_NOW(a_stall_has_item, i_clk, i_rst_n,
        !s_axis_tready, r_in_valid,
        "input stalled with empty input register")

endmodule
